/* rtl/assert_macros.svh */
//------------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the ordered list table engine.
//------------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under the reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication under the reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/olt_pkg.sv */
//------------------------------------------------------------------------------
// olt_pkg
// Sizes, codes and shared types of the ordered list table engine.
//------------------------------------------------------------------------------
package olt_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int DATA_W   = 32;
    localparam int CMD_W    = 2;
    localparam int STAT_W   = 2;
    localparam int POS_W    = 4;
    localparam int ICNT_W   = 5;

    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd3;

    localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

    typedef logic signed [DATA_W-1:0] data_t;

    // broadcast to every cell
    typedef struct packed {
        logic             capture;  // latch compare flags against the new value
        logic             insert;   // open a gap at pos and load the value
        logic             remove;   // close the gap at pos
        logic [IDX_W-1:0] pos;
    } olt_ctrl_t;

endpackage

/* rtl/olt_in_if.sv */
//------------------------------------------------------------------------------
// olt_in_if
// Command channel: valid/ready with command and operand.
//------------------------------------------------------------------------------
interface olt_in_if;
    import olt_pkg::*;

    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    data_t            operand_value;

    modport source (output valid, output cmd, output operand_value, input ready);
    modport sink   (input valid, input cmd, input operand_value, output ready);
endinterface

/* rtl/olt_out_if.sv */
//------------------------------------------------------------------------------
// olt_out_if
// Result channel: valid/ready with status, position and count.
//------------------------------------------------------------------------------
interface olt_out_if;
    import olt_pkg::*;

    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  position;
    logic [ICNT_W-1:0] item_count;

    modport source (output valid, output status, output position, output item_count,
                    input ready);
    modport sink   (input valid, input status, input position, input item_count,
                    output ready);
endinterface

/* rtl/olt_cell.sv */
//------------------------------------------------------------------------------
// olt_cell
// One list slot: holds an entry, flags compares, shifts with its neighbors.
//------------------------------------------------------------------------------
module olt_cell (
    input  logic                           clk,
    input  olt_pkg::olt_ctrl_t             ctrl,
    input  logic [olt_pkg::IDX_W-1:0]      cell_index,
    input  olt_pkg::data_t                 cmp_value,
    input  olt_pkg::data_t                 load_value,
    input  olt_pkg::data_t                 left_entry,
    input  olt_pkg::data_t                 right_entry,
    output olt_pkg::data_t                 entry,
    output logic                           eq_flag,
    output logic                           lt_flag
);
    import olt_pkg::*;

    data_t entry_reg;
    data_t entry_next;
    logic  eq_reg;
    logic  lt_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.insert)
        begin
            if (cell_index == ctrl.pos)
                entry_next = load_value;
            else if (cell_index > ctrl.pos)
                entry_next = left_entry;
        end
        else if (ctrl.remove)
        begin
            if (cell_index >= ctrl.pos)
                entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        if (ctrl.capture)
        begin
            eq_reg <= (entry_reg == cmp_value);
            lt_reg <= (entry_reg < cmp_value);
        end
    end

    assign entry   = entry_reg;
    assign eq_flag = eq_reg;
    assign lt_flag = lt_reg;

endmodule

/* rtl/ordered_list_table_engine.sv */
//------------------------------------------------------------------------------
// ordered_list_table_engine
// Bounded ordered list of signed 32-bit values kept in a chain of cells.
//------------------------------------------------------------------------------
// Usage:
//  request : valid/ready transfer of cmd (append, ordered insert, remove,
//            search) and operand_value. One transfer yields one result.
//  result  : valid/ready transfer of status, position and item_count.
//  Timing  : when a command is taken every cell compares its entry with the
//            operand and latches the flags. In the evaluate cycle a priority
//            pick over the flags sets the position; an insert or remove shifts
//            the cells from there on one place (open or close a gap) as the
//            result is registered. No command is taken during evaluation.
//  Stall   : the result sits in an output register; one more command may be
//            taken while it waits, and that command holds in its evaluate
//            cycle until the output register frees up.
//  Reset   : clears the count and all valid flags; the cell contents are
//            left as they are and are never read before being written.
//------------------------------------------------------------------------------
`include "assert_macros.svh"

module ordered_list_table_engine (
    input  logic      clk,
    input  logic      rst_n,
    olt_in_if.sink    request,
    olt_out_if.source result
);
    import olt_pkg::*;

    // captured command
    logic [CMD_W-1:0]  cmd_reg;
    data_t             value_reg;
    logic              eval_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    // output register
    logic              out_valid_reg;
    logic [STAT_W-1:0] status_reg;
    logic [STAT_W-1:0] status_next;
    logic [POS_W-1:0]  position_reg;
    logic [IDX_W-1:0]  pos_next;
    logic [ICNT_W-1:0] item_count_reg;

    // cell chain
    data_t             entry_arr [CAPACITY];
    logic [CAPACITY-1:0] eq_vec;
    logic [CAPACITY-1:0] lt_vec;
    logic [CAPACITY-1:0] valid_vec;
    logic [CAPACITY-1:0] eq_hit;
    logic [CAPACITY-1:0] ge_hit;

    logic              capture;
    logic              fire;
    logic              full;
    logic              head_gt;
    logic              eq_any;
    logic              ge_any;
    logic [IDX_W-1:0]  eq_pos;
    logic [IDX_W-1:0]  ge_pos;
    olt_ctrl_t         ctrl;

    assign request.ready = !eval_reg;
    assign capture       = request.valid && !eval_reg;
    assign fire          = eval_reg && (!out_valid_reg || result.ready);
    assign full          = (count_reg == CNT_W'(CAPACITY));

    // first-match picks over the latched compare flags
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
            valid_vec[i] = (CNT_W'(i) < count_reg);
        eq_hit = eq_vec & valid_vec;
        // insert point after the head: first entry that is not smaller
        ge_hit = ~lt_vec & valid_vec;
        ge_hit[0] = 1'b0;
        head_gt = valid_vec[0] && !lt_vec[0] && !eq_vec[0];

        eq_any = |eq_hit;
        ge_any = |ge_hit;
        eq_pos = '0;
        ge_pos = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (eq_hit[i])
                eq_pos = IDX_W'(i);
            if (ge_hit[i])
                ge_pos = IDX_W'(i);
        end
    end

    // command decode in the evaluate cycle
    always_comb
    begin
        ctrl.capture = capture;
        ctrl.insert  = 1'b0;
        ctrl.remove  = 1'b0;
        pos_next     = '0;
        status_next  = ST_DONE;
        count_next   = count_reg;

        case (cmd_reg)
            CMD_APPEND, CMD_INSERT:
            begin
                if (full)
                    status_next = ST_FULL;
                else
                begin
                    ctrl.insert = fire;
                    count_next  = count_reg + 1'b1;
                    if (cmd_reg == CMD_APPEND)
                        pos_next = IDX_W'(count_reg);
                    else if (!valid_vec[0] || head_gt)
                        pos_next = '0;
                    else if (ge_any)
                        pos_next = ge_pos;
                    else
                        pos_next = IDX_W'(count_reg);
                end
            end
            CMD_REMOVE:
            begin
                if (!eq_any)
                    status_next = ST_NOT_FOUND;
                else
                begin
                    ctrl.remove = fire;
                    pos_next    = eq_pos;
                    count_next  = count_reg - 1'b1;
                end
            end
            CMD_SEARCH:
            begin
                if (!eq_any)
                    status_next = ST_NOT_FOUND;
                else
                    pos_next = eq_pos;
            end
            default:
            begin
                status_next = ST_NOT_FOUND;
            end
        endcase
        ctrl.pos = pos_next;
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            data_t left_entry;
            data_t right_entry;

            if (g == 0)
            begin : g_head
                assign left_entry = '0;
            end
            else
            begin : g_body
                assign left_entry = entry_arr[g-1];
            end

            if (g == CAPACITY - 1)
            begin : g_tail
                assign right_entry = '0;
            end
            else
            begin : g_mid
                assign right_entry = entry_arr[g+1];
            end

            olt_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .cell_index  (IDX_W'(g)),
                .cmp_value   (request.operand_value),
                .load_value  (value_reg),
                .left_entry  (left_entry),
                .right_entry (right_entry),
                .entry       (entry_arr[g]),
                .eq_flag     (eq_vec[g]),
                .lt_flag     (lt_vec[g])
            );
        end
    endgenerate

    // command capture
    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            cmd_reg   <= request.cmd;
            value_reg <= request.operand_value;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eval_reg      <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (capture)
                eval_reg <= 1'b1;
            else if (fire)
                eval_reg <= 1'b0;

            if (fire)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg     <= status_next;
            position_reg   <= POS_W'(pos_next);
            item_count_reg <= ICNT_W'(count_next);
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.status     = status_reg;
    assign result.position   = position_reg;
    assign result.item_count = item_count_reg;

    // checks
    `ASSERT_IMPLIES(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(CAPACITY))
    `ASSERT_IMPLIES(a_full_count, clk, rst_n, result.valid && result.status == ST_FULL, result.item_count == ICNT_W'(CAPACITY))
    `ASSERT_IMPLIES(a_miss_pos, clk, rst_n, result.valid && result.status != ST_DONE, result.position == '0)
    `ASSERT_NEXT(a_remove_count, clk, rst_n, ctrl.remove, count_reg == CNT_W'($past(count_reg) - 1'b1))

endmodule
